// ===== design/fepi_pkg.sv =====
package fepi_pkg;

    localparam int FRAC_BITS = 16;

    localparam int SAMPLE_W   = 16;
    localparam int TARGET_W   = 16;
    localparam int ALPHA_W    = 17;
    localparam int ALPHA_FRAC = 16;
    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 8;
    localparam int LIMIT_W    = 20;
    localparam int DRIVE_W    = 22;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam int ERR_W     = SAMPLE_W + 1;
    localparam int FILT_W    = FRAC_BITS + 18;
    localparam int DIFF_W    = FRAC_BITS + 19;
    localparam int INTEG_W   = FRAC_BITS + 21;
    localparam int SUM_W     = FRAC_BITS + 22;
    localparam int ACC_W     = FRAC_BITS + 38;
    localparam int OUT_SHIFT = FRAC_BITS + GAIN_FRAC;
    localparam int Q_W       = ACC_W - OUT_SHIFT;

    localparam int MUL_STEPS = ALPHA_W;
    localparam int CNT_W     = $clog2(MUL_STEPS);

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1 << ALPHA_FRAC);

    localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(200);
    localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = ALPHA_W'(10486);
    localparam logic [GAIN_W-1:0]   KP_RESET     = GAIN_W'(5120);
    localparam logic [GAIN_W-1:0]   KI_RESET     = GAIN_W'(128);
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(380000);

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = CFG_IDX_W'(4);

endpackage

// ===== design/fepi_in_if.sv =====
interface fepi_in_if
    import fepi_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] encoder_count;

    modport source (output valid, output encoder_count, input ready);
    modport sink (input valid, input encoder_count, output ready);
endinterface

// ===== design/fepi_out_if.sv =====
interface fepi_out_if
    import fepi_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive_value;

    modport source (output valid, output drive_value, input ready);
    modport sink (input valid, input drive_value, output ready);
endinterface

// ===== design/filtered_error_pi_speed_controller_core.sv =====
// Channel   | Role    | Beat payload
// ----------+---------+----------------------------------------
// samples   | sink    | encoder_count, signed 16 bits
// drives    | source  | drive_value, signed 22 bits
// cfg_*     | write   | cfg_index 3 bits, cfg_data 20 bits
//
// A sample is taken only while the block is idle; its drive value is loaded into the
// output register in the finish state, and no new sample is taken before that.
// The work runs through two 17-step shift-and-add multiplier passes, one for the
// filter weight and one for both gains together, plus five further steps.
// A stalled output beat holds the result and delays the return to idle until it is taken.
// Reset is asynchronous and active low; it restores the register defaults and zeroes
// the filter and integral state.
module filtered_error_pi_speed_controller_core
    import fepi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    fepi_in_if.sink               samples,
    fepi_out_if.source            drives
);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_MUL_FILT = 8'b0000_0010,
        ST_UPD_FILT = 8'b0000_0100,
        ST_SUM_INT  = 8'b0000_1000,
        ST_CLAMP    = 8'b0001_0000,
        ST_PREP_OUT = 8'b0010_0000,
        ST_MUL_OUT  = 8'b0100_0000,
        ST_FINISH   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [TARGET_W-1:0] target_reg;
    logic [ALPHA_W-1:0]  alpha_reg;
    logic [GAIN_W-1:0]   kp_reg;
    logic [GAIN_W-1:0]   ki_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    logic [FILT_W-1:0]  filt_reg, filt_next;
    logic [INTEG_W-1:0] integ_reg, integ_next;

    logic [DIFF_W-1:0]  x_reg, x_next;
    logic [SUM_W-1:0]   xy_reg, xy_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [ALPHA_W-1:0] mpa_reg, mpa_next;
    logic [ALPHA_W-1:0] mpb_reg, mpb_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic               out_valid_reg, out_valid_next;
    logic [DRIVE_W-1:0] drive_reg, drive_next;

    logic               accept;
    logic               out_free;
    logic [ALPHA_W-1:0] alpha_sat;
    logic [ERR_W-1:0]   err;
    logic [DIFF_W-1:0]  err_scaled;
    logic [DIFF_W-1:0]  diff;
    logic [ACC_W-1:0]   addend;
    logic [ACC_W-1:0]   acc_step;
    logic [SUM_W-1:0]   int_sum;
    logic [SUM_W-1:0]   lim_pos;
    logic [SUM_W-1:0]   lim_neg;
    logic [Q_W-1:0]     q_floor;
    logic [Q_W-1:0]     q_trunc;
    logic               q_round;
    logic [Q_W-1:0]     q_max;
    logic [Q_W-1:0]     q_min;
    logic [DRIVE_W-1:0] drive_sat;

    assign samples.ready     = (state_reg == ST_IDLE);
    assign accept            = samples.valid && samples.ready;
    assign drives.valid      = out_valid_reg;
    assign drives.drive_value = drive_reg;
    assign out_free          = !out_valid_reg || drives.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RESET;
            alpha_reg  <= ALPHA_RESET;
            kp_reg     <= KP_RESET;
            ki_reg     <= KI_RESET;
            limit_reg  <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TARGET_SPEED:   target_reg <= cfg_data[TARGET_W-1:0];
                REG_FILTER_ALPHA:   alpha_reg  <= cfg_data[ALPHA_W-1:0];
                REG_PROP_GAIN:      kp_reg     <= cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN:     ki_reg     <= cfg_data[GAIN_W-1:0];
                REG_INTEGRAL_LIMIT: limit_reg  <= cfg_data[LIMIT_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        alpha_sat  = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
        err        = {target_reg[TARGET_W-1], target_reg}
                   - {samples.encoder_count[SAMPLE_W-1], samples.encoder_count};
        err_scaled = {{(DIFF_W-ERR_W-FRAC_BITS){err[ERR_W-1]}}, err, {FRAC_BITS{1'b0}}};
        diff       = err_scaled - {{(DIFF_W-FILT_W){filt_reg[FILT_W-1]}}, filt_reg};

        case ({mpa_reg[ALPHA_W-1], mpb_reg[ALPHA_W-1]})
            2'b10:   addend = {{(ACC_W-DIFF_W){x_reg[DIFF_W-1]}}, x_reg};
            2'b01:   addend = {{(ACC_W-INTEG_W){integ_reg[INTEG_W-1]}}, integ_reg};
            2'b11:   addend = {{(ACC_W-SUM_W){xy_reg[SUM_W-1]}}, xy_reg};
            default: addend = '0;
        endcase
        acc_step = {acc_reg[ACC_W-2:0], 1'b0} + addend;

        int_sum = {{(SUM_W-INTEG_W){integ_reg[INTEG_W-1]}}, integ_reg}
                + {{(SUM_W-FILT_W){filt_reg[FILT_W-1]}}, filt_reg};
        lim_pos = {{(SUM_W-LIMIT_W-FRAC_BITS){1'b0}}, limit_reg, {FRAC_BITS{1'b0}}};
        lim_neg = '0 - lim_pos;

        q_floor   = acc_reg[ACC_W-1:OUT_SHIFT];
        q_round   = acc_reg[ACC_W-1] && (|acc_reg[OUT_SHIFT-1:0]);
        q_trunc   = q_floor + {{(Q_W-1){1'b0}}, q_round};
        q_max     = {{(Q_W-DRIVE_W+1){1'b0}}, {(DRIVE_W-1){1'b1}}};
        q_min     = {{(Q_W-DRIVE_W+1){1'b1}}, {(DRIVE_W-1){1'b0}}};
        if ($signed(q_trunc) > $signed(q_max))
        begin
            drive_sat = q_max[DRIVE_W-1:0];
        end
        else if ($signed(q_trunc) < $signed(q_min))
        begin
            drive_sat = q_min[DRIVE_W-1:0];
        end
        else
        begin
            drive_sat = q_trunc[DRIVE_W-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        filt_next      = filt_reg;
        integ_next     = integ_reg;
        x_next         = x_reg;
        xy_next        = xy_reg;
        acc_next       = acc_reg;
        mpa_next       = mpa_reg;
        mpb_next       = mpb_reg;
        cnt_next       = cnt_reg;
        drive_next     = drive_reg;
        out_valid_next = out_valid_reg;

        if (drives.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    x_next     = diff;
                    mpa_next   = alpha_sat;
                    mpb_next   = '0;
                    acc_next   = '0;
                    cnt_next   = CNT_W'(MUL_STEPS - 1);
                    state_next = ST_MUL_FILT;
                end
            end
            ST_MUL_FILT, ST_MUL_OUT:
            begin
                acc_next = acc_step;
                mpa_next = {mpa_reg[ALPHA_W-2:0], 1'b0};
                mpb_next = {mpb_reg[ALPHA_W-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = (state_reg == ST_MUL_FILT) ? ST_UPD_FILT : ST_FINISH;
                end
            end
            ST_UPD_FILT:
            begin
                filt_next  = filt_reg + acc_reg[ALPHA_FRAC+FILT_W-1:ALPHA_FRAC];
                state_next = ST_SUM_INT;
            end
            ST_SUM_INT:
            begin
                xy_next    = int_sum;
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                if ($signed(xy_reg) > $signed(lim_pos))
                begin
                    integ_next = lim_pos[INTEG_W-1:0];
                end
                else if ($signed(xy_reg) < $signed(lim_neg))
                begin
                    integ_next = lim_neg[INTEG_W-1:0];
                end
                else
                begin
                    integ_next = xy_reg[INTEG_W-1:0];
                end
                state_next = ST_PREP_OUT;
            end
            ST_PREP_OUT:
            begin
                x_next     = {{(DIFF_W-FILT_W){filt_reg[FILT_W-1]}}, filt_reg};
                xy_next    = int_sum;
                mpa_next   = {{(ALPHA_W-GAIN_W){1'b0}}, kp_reg};
                mpb_next   = {{(ALPHA_W-GAIN_W){1'b0}}, ki_reg};
                acc_next   = '0;
                cnt_next   = CNT_W'(MUL_STEPS - 1);
                state_next = ST_MUL_OUT;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    drive_next     = drive_sat;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            filt_reg      <= '0;
            integ_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            filt_reg      <= filt_next;
            integ_reg     <= integ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        xy_reg    <= xy_next;
        acc_reg   <= acc_next;
        mpa_reg   <= mpa_next;
        mpb_reg   <= mpb_next;
        cnt_reg   <= cnt_next;
        drive_reg <= drive_next;
    end

endmodule

// ===== design/fepi_checker.sv =====
module fepi_checker
    import fepi_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    fepi_in_if.sink    samples,
    fepi_out_if.source drives
);

    a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        drives.valid && !drives.ready |=> drives.valid)
        else $error("Output beat withdrawn before it was taken.");

    a_out_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        drives.valid && !drives.ready |=> $stable(drives.drive_value))
        else $error("Stalled output beat changed its payload.");

    a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid && samples.ready |=> !samples.ready)
        else $error("Input still ready in the cycle after a sample beat.");

    a_result_ends_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(drives.valid) |-> samples.ready)
        else $error("A result appeared while the block was still busy.");

endmodule

bind filtered_error_pi_speed_controller_core fepi_checker u_fepi_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .samples (samples),
    .drives  (drives)
);

// ===== sim/filtered_error_pi_speed_controller_core_tb.sv =====
module filtered_error_pi_speed_controller_core_tb
    import fepi_pkg::*;
();

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 1530;
    localparam int HOLD_OFF      = 400;
    localparam int SETTLE_CYCLES = 80;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_INTEGRAL_LIMIT + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = {CFG_IDX_W{1'b1}};

    class pi_drive_scoreboard;
        logic signed [TARGET_W-1:0] target;
        logic [ALPHA_W-1:0]         alpha;
        logic [GAIN_W-1:0]          kp;
        logic [GAIN_W-1:0]          ki;
        logic [LIMIT_W-1:0]         limit;
        longint                     filtered;
        longint                     integral;
        logic signed [DRIVE_W-1:0]  drive_q[$];
        int unsigned                mismatches;

        function new();
            target     = TARGET_RESET;
            alpha      = ALPHA_RESET;
            kp         = KP_RESET;
            ki         = KI_RESET;
            limit      = LIMIT_RESET;
            filtered   = 0;
            integral   = 0;
            mismatches = 0;
        endfunction

        function void report(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            mismatches++;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TARGET_SPEED:   target = data[TARGET_W-1:0];
                REG_FILTER_ALPHA:   alpha  = data[ALPHA_W-1:0];
                REG_PROP_GAIN:      kp     = data[GAIN_W-1:0];
                REG_INTEG_GAIN:     ki     = data[GAIN_W-1:0];
                REG_INTEGRAL_LIMIT: limit  = data[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] sample);
            longint err;
            longint weight;
            longint bound;
            longint acc;
            longint drive;
            longint drive_max;
            err       = longint'(target) - longint'(sample);
            weight    = (alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha);
            acc       = filtered * (longint'(ALPHA_ONE) - weight) + (err <<< FRAC_BITS) * weight;
            filtered  = acc >>> ALPHA_FRAC;
            integral  = integral + filtered;
            bound     = longint'(limit) <<< FRAC_BITS;
            if (integral > bound)
                integral = bound;
            if (integral < -bound)
                integral = -bound;
            acc       = longint'(kp) * filtered + longint'(ki) * integral;
            drive     = acc / (longint'(1) <<< OUT_SHIFT);
            drive_max = (longint'(1) <<< (DRIVE_W - 1)) - 1;
            if (drive > drive_max)
                drive = drive_max;
            if (drive < -drive_max - 1)
                drive = -drive_max - 1;
            drive_q.push_back(drive[DRIVE_W-1:0]);
        endfunction

        function void check_drive(logic signed [DRIVE_W-1:0] got);
            logic signed [DRIVE_W-1:0] want;
            if (drive_q.size() == 0)
            begin
                report($sformatf("drive beat %0d arrived with no sample outstanding", got));
            end
            else
            begin
                want = drive_q.pop_front();
                if (got !== want)
                    report($sformatf("drive_value got %0d, expected %0d", got, want));
            end
        endfunction

        function void check_empty();
            if (drive_q.size() != 0)
                report($sformatf("%0d drive beats never arrived", drive_q.size()));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    fepi_in_if  sample_ch();
    fepi_out_if drive_ch();

    filtered_error_pi_speed_controller_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (sample_ch),
        .drives    (drive_ch)
    );

    pi_drive_scoreboard sb = new();

    int                         samples_sent   = 0;
    int                         drives_seen    = 0;
    int                         burst_left     = 0;
    int                         cycle_count    = 0;
    bit                         random_started = 1'b0;
    bit                         hold_off_done  = 1'b0;
    logic signed [TARGET_W-1:0] target_now     = TARGET_RESET;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (cfg_we)
            sb.write_reg(cfg_index, cfg_data);
        if (rst_n && sample_ch.valid && sample_ch.ready)
            sb.note_sample(sample_ch.encoder_count);
        if (rst_n && drive_ch.valid && drive_ch.ready)
        begin
            sb.check_drive(drive_ch.drive_value);
            drives_seen++;
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // The receiver keeps its own stall pattern, with one long hold-off once random
    // traffic has begun so that the block fills and refuses further sample beats.
    initial
    begin
        int seg_len;
        int mode;
        int n;
        drive_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (random_started && !hold_off_done)
            begin
                hold_off_done = 1'b1;
                drive_ch.ready <= 1'b0;
                for (n = 0; n < HOLD_OFF; n++)
                    @(posedge clk);
            end
            else
            begin
                seg_len = $urandom_range(10, 150);
                mode    = $urandom_range(0, 3);
                repeat (seg_len)
                begin
                    case (mode)
                        0:       drive_ch.ready <= 1'b1;
                        1:       drive_ch.ready <= 1'($urandom_range(0, 1));
                        2:       drive_ch.ready <= ($urandom_range(0, 4) != 0);
                        default: drive_ch.ready <= ($urandom_range(0, 4) == 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : $urandom_range(0, 4);
            if (gap > 0)
            begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        sample_ch.valid         <= 1'b1;
        sample_ch.encoder_count <= value;
        samples_sent++;
        do
            @(posedge clk);
        while (!sample_ch.ready);
    endtask

    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (drives_seen != samples_sent)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] t, input logic [CFG_DATA_W-1:0] a,
                             input logic [CFG_DATA_W-1:0] p, input logic [CFG_DATA_W-1:0] i,
                             input logic [CFG_DATA_W-1:0] l);
        logic [CFG_IDX_W-1:0] spare;
        drain();
        spare = CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST));
        write_reg(spare, CFG_DATA_W'($urandom));
        write_reg(REG_TARGET_SPEED, t);
        write_reg(REG_FILTER_ALPHA, a);
        write_reg(REG_PROP_GAIN, p);
        write_reg(REG_INTEG_GAIN, i);
        write_reg(REG_INTEGRAL_LIMIT, l);
        cfg_we <= 1'b0;
        target_now = t[TARGET_W-1:0];
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(logic [CFG_IDX_W-1:0] idx);
        logic [CFG_DATA_W-1:0] v;
        int                    pick;
        v    = CFG_DATA_W'($urandom);
        pick = $urandom_range(0, 5);
        case (idx)
            REG_TARGET_SPEED:
                case (pick)
                    0:       v[TARGET_W-1:0] = {1'b1, {(TARGET_W-1){1'b0}}};
                    1:       v[TARGET_W-1:0] = {1'b0, {(TARGET_W-1){1'b1}}};
                    2:       v[TARGET_W-1:0] = '0;
                    3:       v[TARGET_W-1:0] = TARGET_RESET;
                    default: ;
                endcase
            REG_FILTER_ALPHA:
                case (pick)
                    0:       v[ALPHA_W-1:0] = '0;
                    1:       v[ALPHA_W-1:0] = ALPHA_ONE;
                    2:       v[ALPHA_W-1:0] =
                                 ALPHA_W'($urandom_range(ALPHA_ONE + 1, {ALPHA_W{1'b1}}));
                    3:       v[ALPHA_W-1:0] = ALPHA_W'($urandom_range(1, 4096));
                    default: v[ALPHA_W-1:0] = ALPHA_W'($urandom_range(1, ALPHA_ONE - 1));
                endcase
            REG_PROP_GAIN, REG_INTEG_GAIN:
                case (pick)
                    0:       v[GAIN_W-1:0] = '0;
                    1:       v[GAIN_W-1:0] = '1;
                    2, 3:    v[GAIN_W-1:0] = GAIN_W'($urandom_range(0, 8192));
                    default: ;
                endcase
            default:
                case (pick)
                    0:       v = '0;
                    1:       v = '1;
                    2:       v = CFG_DATA_W'($urandom_range(0, 100));
                    3:       v = LIMIT_RESET;
                    default: ;
                endcase
        endcase
        return v;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic signed [SAMPLE_W-1:0] s;
        case ($urandom_range(0, 7))
            0:
                case ($urandom_range(0, 3))
                    0:       s = {1'b1, {(SAMPLE_W-1){1'b0}}};
                    1:       s = {1'b0, {(SAMPLE_W-1){1'b1}}};
                    2:       s = '0;
                    default: s = '1;
                endcase
            1, 2:    s = SAMPLE_W'(int'(target_now) + int'($urandom_range(0, 128)) - 64);
            default: s = SAMPLE_W'($urandom);
        endcase
        return s;
    endfunction

    initial
    begin
        int items_left;
        int phase_len;
        rst_n                   <= 1'b0;
        cfg_we                  <= 1'b0;
        cfg_index               <= '0;
        cfg_data                <= '0;
        sample_ch.valid         <= 1'b0;
        sample_ch.encoder_count <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_sample(16'sd0);
        send_sample(16'sd200);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(-16'sd1);
        send_sample(16'sd1);

        configure(20'h07FFF, 20'h10000, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        repeat (3) send_sample(16'sh8000);

        configure(20'hF8000, 20'hFFFFF, 20'h0FFFF, 20'h0FFFF, 20'h00000);
        repeat (3) send_sample(16'sh7FFF);

        configure(20'h00000, 20'h00000, 20'h00000, 20'h00000, 20'h00001);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sd0);

        configure(20'd200, 20'h00001, 20'h00001, 20'h0FFFF, 20'h00001);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sd100);
        send_sample(16'sd300);

        items_left = RANDOM_ITEMS;
        while (items_left > 0)
        begin
            phase_len = $urandom_range(100, 200);
            if (phase_len > items_left)
                phase_len = items_left;
            configure(pick_reg_value(REG_TARGET_SPEED), pick_reg_value(REG_FILTER_ALPHA),
                      pick_reg_value(REG_PROP_GAIN), pick_reg_value(REG_INTEG_GAIN),
                      pick_reg_value(REG_INTEGRAL_LIMIT));
            random_started = 1'b1;
            repeat (phase_len) send_sample(pick_sample());
            items_left -= phase_len;
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        sb.check_empty();
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/fepi_pkg.sv
design/fepi_in_if.sv
design/fepi_out_if.sv
design/filtered_error_pi_speed_controller_core.sv
design/fepi_checker.sv
sim/filtered_error_pi_speed_controller_core_tb.sv
